// ----- rtl/crmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crmf_pkg: shared types and constants of the CSV record match filter
// Channel payloads, configuration image, register indexes and column modes.
// ----------------------------------------------------------------------------
package crmf_pkg;

    // Default sizing, handed to the top level parameters
    localparam int MAX_MATCH_BYTES_DEF = 8;
    localparam int MAX_FIELDS_DEF      = 256;

    // Configuration port sizing
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR          = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DROP_MODE          = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_MODE        = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_NUMBER      = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_BYTES        = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_LENGTH       = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_NAME_BYTES  = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_NAME_LENGTH = 8'd7;

    // Column modes; the unused code behaves as any-column
    localparam logic [1:0] MODE_ANY    = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_NAME   = 2'd2;

    // Special bytes and reset values
    localparam logic [7:0] NEWLINE_BYTE        = 8'd10;
    localparam logic [7:0] SEPARATOR_RESET     = 8'd44;
    localparam logic [7:0] COLUMN_NUMBER_RESET = 8'd1;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } byte_t;

    // Output transaction payload
    typedef struct packed {
        logic keep_record;
        logic is_header;
        logic column_absent;
    } verdict_t;

    // Configuration image
    typedef struct packed {
        logic [7:0]  separator;
        logic        drop_mode;
        logic [1:0]  column_mode;
        logic [7:0]  column_number;
        logic [63:0] value_bytes;
        logic [3:0]  value_length;
        logic [63:0] header_name_bytes;
        logic [3:0]  header_name_length;
    } cfg_t;

endpackage

// ----- rtl/crmf_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crmf_parser: record and field tracker with per-byte field compare
// Holds the parse state of the current record and produces one verdict
// when a record closes. All work for a byte is combinational, latched on step.
// ----------------------------------------------------------------------------
module crmf_parser #(
    parameter int MAX_MATCH_BYTES = crmf_pkg::MAX_MATCH_BYTES_DEF,
    parameter int MAX_FIELDS      = crmf_pkg::MAX_FIELDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  crmf_pkg::byte_t    byte_in,
    input  crmf_pkg::cfg_t     cfg,
    output logic               result_valid,
    output crmf_pkg::verdict_t result
);

    localparam int BPW = $clog2(MAX_MATCH_BYTES + 2);
    localparam int FCW = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
    localparam logic [BPW-1:0] BP_MAX  = BPW'(MAX_MATCH_BYTES);
    localparam logic [BPW-1:0] BP_SAT  = BPW'(MAX_MATCH_BYTES + 1);
    localparam logic [FCW-1:0] FC_LAST = FCW'(MAX_FIELDS - 1);

    logic [FCW-1:0] field_count_reg,   field_count_next;
    logic           field_overflow_reg, field_overflow_next;
    logic [BPW-1:0] byte_position_reg, byte_position_next;
    logic           value_eq_reg,      value_eq_next;
    logic           name_eq_reg,       name_eq_next;
    logic           record_hit_reg,    record_hit_next;
    logic [FCW-1:0] target_column_reg, target_column_next;
    logic           target_found_reg,  target_found_next;
    logic           name_known_reg,    name_known_next;
    logic           header_done_reg,   header_done_next;

    // Next state and verdict for one byte
    always_comb
    begin
        logic           is_nl;
        logic           is_sep;
        logic           do_close;
        logic           do_record;
        logic           eq_v;
        logic           eq_n;
        logic [2:0]     idx;
        logic [3:0]     pos4;
        logic [BPW-1:0] bp_a;
        logic           veq_a;
        logic           neq_a;

        is_nl  = (byte_in.data_byte == crmf_pkg::NEWLINE_BYTE);
        is_sep = !is_nl && (byte_in.data_byte == cfg.separator);

        field_count_next    = field_count_reg;
        field_overflow_next = field_overflow_reg;
        record_hit_next     = record_hit_reg;
        target_column_next  = target_column_reg;
        target_found_next   = target_found_reg;
        name_known_next     = name_known_reg;
        header_done_next    = header_done_reg;

        // Take an ordinary byte into the open field
        bp_a  = byte_position_reg;
        veq_a = value_eq_reg;
        neq_a = name_eq_reg;
        idx   = 3'(byte_position_reg);
        pos4  = 4'(byte_position_reg);
        if (!is_nl && !is_sep)
        begin
            if (byte_position_reg >= BP_MAX || pos4 >= cfg.value_length ||
                cfg.value_bytes[{idx, 3'b000} +: 8] != byte_in.data_byte)
                veq_a = 1'b0;
            if (byte_position_reg >= BP_MAX || pos4 >= cfg.header_name_length ||
                cfg.header_name_bytes[{idx, 3'b000} +: 8] != byte_in.data_byte)
                neq_a = 1'b0;
            if (byte_position_reg != BP_SAT)
                bp_a = byte_position_reg + BPW'(1);
        end

        do_record = is_nl || byte_in.stream_end;
        do_close  = is_sep || (do_record && bp_a != '0);

        byte_position_next = bp_a;
        value_eq_next      = veq_a;
        name_eq_next       = neq_a;

        // Close the field: update target and hit, advance the field count
        eq_v = veq_a && (4'(bp_a) == cfg.value_length);
        eq_n = neq_a && (4'(bp_a) == cfg.header_name_length);
        if (do_close)
        begin
            if (!header_done_reg)
            begin
                if (!name_known_reg && !field_overflow_reg && eq_n)
                begin
                    target_column_next = field_count_reg;
                    name_known_next    = 1'b1;
                end
            end
            else
            begin
                case (cfg.column_mode)
                    crmf_pkg::MODE_NUMBER:
                    begin
                        if (cfg.column_number != 8'd0 && !field_overflow_reg &&
                            8'(field_count_reg) == cfg.column_number - 8'd1)
                        begin
                            target_found_next = 1'b1;
                            record_hit_next   = eq_v;
                        end
                    end
                    crmf_pkg::MODE_NAME:
                    begin
                        if (name_known_reg && !field_overflow_reg &&
                            field_count_reg == target_column_reg)
                        begin
                            target_found_next = 1'b1;
                            record_hit_next   = eq_v;
                        end
                    end
                    default:
                    begin
                        if (eq_v)
                            record_hit_next = 1'b1;
                    end
                endcase
            end
            if (!field_overflow_reg)
            begin
                if (field_count_reg == FC_LAST)
                    field_overflow_next = 1'b1;
                else
                    field_count_next = field_count_reg + FCW'(1);
            end
            byte_position_next = '0;
            value_eq_next      = 1'b1;
            name_eq_next       = 1'b1;
        end

        // Close the record and form its verdict
        result_valid = do_record;
        if (!header_done_reg)
        begin
            result.keep_record   = 1'b1;
            result.is_header     = 1'b1;
            result.column_absent = (cfg.column_mode == crmf_pkg::MODE_NAME) &&
                                   !name_known_next;
        end
        else
        begin
            result.keep_record   = record_hit_next ^ cfg.drop_mode;
            result.is_header     = 1'b0;
            result.column_absent = (cfg.column_mode == crmf_pkg::MODE_NUMBER ||
                                    cfg.column_mode == crmf_pkg::MODE_NAME) &&
                                   !target_found_next;
        end
        if (do_record)
        begin
            header_done_next    = 1'b1;
            field_count_next    = '0;
            field_overflow_next = 1'b0;
            byte_position_next  = '0;
            value_eq_next       = 1'b1;
            name_eq_next        = 1'b1;
            record_hit_next     = 1'b0;
            target_found_next   = 1'b0;
        end

        // Stream end: the next byte opens a new header
        if (byte_in.stream_end)
        begin
            header_done_next   = 1'b0;
            name_known_next    = 1'b0;
            target_column_next = '0;
        end
    end

    // Hold parse state, advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_count_reg    <= '0;
            field_overflow_reg <= 1'b0;
            byte_position_reg  <= '0;
            value_eq_reg       <= 1'b1;
            name_eq_reg        <= 1'b1;
            record_hit_reg     <= 1'b0;
            target_column_reg  <= '0;
            target_found_reg   <= 1'b0;
            name_known_reg     <= 1'b0;
            header_done_reg    <= 1'b0;
        end
        else if (step)
        begin
            field_count_reg    <= field_count_next;
            field_overflow_reg <= field_overflow_next;
            byte_position_reg  <= byte_position_next;
            value_eq_reg       <= value_eq_next;
            name_eq_reg        <= name_eq_next;
            record_hit_reg     <= record_hit_next;
            target_column_reg  <= target_column_next;
            target_found_reg   <= target_found_next;
            name_known_reg     <= name_known_next;
            header_done_reg    <= header_done_next;
        end
    end

endmodule

// ----- rtl/csv_record_match_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_match_filter: keep or drop verdicts for CSV records
// Splits a byte stream into records and fields, matches fields against a
// configured value and reports one verdict per finished record.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel    - one CSV byte per transaction, stream_end on the last.
//   verdict channel - one transaction per record closed by a newline or by
//                     stream_end; the first record of a stream is the header.
//   cfg channel     - register index and data; always ready, written between
//                     transactions while no verdict is pending.
// Throughput: one byte per cycle unless a verdict stalls. Latency: a verdict
// appears in the cycle after the closing byte; parse state updates in the
// same cycle as the byte, between the byte and the verdict register.
// A stalled verdict keeps byte_ready high only if the receiver takes it in
// that cycle; otherwise bytes wait, since any byte may close a record.
// Reset clears parse state and loads register defaults (separator comma,
// column number 1, all else zero); no verdict is pending after reset.
// ----------------------------------------------------------------------------
module csv_record_match_filter #(
    parameter int MAX_MATCH_BYTES = crmf_pkg::MAX_MATCH_BYTES_DEF,
    parameter int MAX_FIELDS      = crmf_pkg::MAX_FIELDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             byte_valid,
    output logic                             byte_ready,
    input  crmf_pkg::byte_t                  byte_data,
    output logic                             verdict_valid,
    input  logic                             verdict_ready,
    output crmf_pkg::verdict_t               verdict_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crmf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crmf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    crmf_pkg::cfg_t     cfg_reg;
    logic               verdict_valid_reg;
    crmf_pkg::verdict_t verdict_reg;
    logic               step;
    logic               result_valid;
    crmf_pkg::verdict_t result;

    assign cfg_ready     = 1'b1;
    assign byte_ready    = !verdict_valid_reg || verdict_ready;
    assign step          = byte_valid && byte_ready;
    assign verdict_valid = verdict_valid_reg;
    assign verdict_data  = verdict_reg;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.separator          <= crmf_pkg::SEPARATOR_RESET;
            cfg_reg.drop_mode          <= 1'b0;
            cfg_reg.column_mode        <= crmf_pkg::MODE_ANY;
            cfg_reg.column_number      <= crmf_pkg::COLUMN_NUMBER_RESET;
            cfg_reg.value_bytes        <= '0;
            cfg_reg.value_length       <= '0;
            cfg_reg.header_name_bytes  <= '0;
            cfg_reg.header_name_length <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                crmf_pkg::REG_SEPARATOR:          cfg_reg.separator     <= cfg_data[7:0];
                crmf_pkg::REG_DROP_MODE:          cfg_reg.drop_mode     <= cfg_data[0];
                crmf_pkg::REG_COLUMN_MODE:        cfg_reg.column_mode   <= cfg_data[1:0];
                crmf_pkg::REG_COLUMN_NUMBER:      cfg_reg.column_number <= cfg_data[7:0];
                crmf_pkg::REG_VALUE_BYTES:        cfg_reg.value_bytes   <= cfg_data;
                crmf_pkg::REG_VALUE_LENGTH:       cfg_reg.value_length  <= cfg_data[3:0];
                crmf_pkg::REG_HEADER_NAME_BYTES:  cfg_reg.header_name_bytes <= cfg_data;
                crmf_pkg::REG_HEADER_NAME_LENGTH:
                    cfg_reg.header_name_length <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    crmf_parser #(
        .MAX_MATCH_BYTES (MAX_MATCH_BYTES),
        .MAX_FIELDS      (MAX_FIELDS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .byte_in      (byte_data),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    // Hold the verdict until taken; load a new one on a closing byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_valid_reg <= 1'b0;
        end
        else if (step && result_valid)
        begin
            verdict_valid_reg <= 1'b1;
        end
        else if (verdict_ready)
        begin
            verdict_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result_valid)
            verdict_reg <= result;
    end

    // Header verdicts always keep the record
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && verdict_data.is_header |-> verdict_data.keep_record)
        else $error("header verdict marked as dropped");

    // A newline always closes a record
    assert property (@(posedge clk) disable iff (!rst_n)
        step && byte_data.data_byte == crmf_pkg::NEWLINE_BYTE |=> verdict_valid)
        else $error("newline produced no verdict");

    // An ordinary byte mid-stream closes nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        step && byte_data.data_byte != crmf_pkg::NEWLINE_BYTE &&
        !byte_data.stream_end && verdict_ready |=> !verdict_valid)
        else $error("verdict without record end");

endmodule

// ----- tb/sv/tb_csv_record_match_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csv_record_match_filter: self-checking bench for the CSV record filter
// Streams directed and generated CSV text through the byte channel and
// predicts every record verdict in a scoreboard class. Results are checked
// in order as they leave the verdict channel. Each phase loads new settings
// while the filter is idle, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_csv_record_match_filter;

    import crmf_pkg::*;

    localparam int          HALF_PERIOD  = 1;
    localparam int          RESET_CYCLES = 7;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          QUIET_LIMIT  = 3000;
    localparam int          PHASE_BYTES  = 130;
    localparam int          MATCH_BYTES  = MAX_MATCH_BYTES_DEF;
    localparam int          FIELD_SLOTS  = MAX_FIELDS_DEF;
    // Spare column mode code, handled as any-column
    localparam logic [1:0]  MODE_SPARE   = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the record parse and holds the expected verdicts
    // ------------------------------------------------------------------------
    class csv_verdict_board;
        cfg_t        regs;
        logic [7:0]  field_idx;
        bit          field_sat;
        int unsigned byte_pos;
        bit          value_eq;
        bit          name_eq;
        bit          hit;
        logic [7:0]  target_col;
        bit          target_seen;
        bit          name_seen;
        bit          header_done;
        verdict_t    expected_verdicts[$];
        int unsigned mismatches;
        int unsigned verdicts_seen;

        function new();
            regs               = '0;
            regs.separator     = SEPARATOR_RESET;
            regs.column_number = COLUMN_NUMBER_RESET;
            field_idx          = '0;
            field_sat          = 1'b0;
            byte_pos           = 0;
            value_eq           = 1'b1;
            name_eq            = 1'b1;
            hit                = 1'b0;
            target_col         = '0;
            target_seen        = 1'b0;
            name_seen          = 1'b0;
            header_done        = 1'b0;
            mismatches         = 0;
            verdicts_seen      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SEPARATOR:          regs.separator          = data[7:0];
                REG_DROP_MODE:          regs.drop_mode          = data[0];
                REG_COLUMN_MODE:        regs.column_mode        = data[1:0];
                REG_COLUMN_NUMBER:      regs.column_number      = data[7:0];
                REG_VALUE_BYTES:        regs.value_bytes        = data;
                REG_VALUE_LENGTH:       regs.value_length       = data[3:0];
                REG_HEADER_NAME_BYTES:  regs.header_name_bytes  = data;
                REG_HEADER_NAME_LENGTH: regs.header_name_length = data[3:0];
                default: ;
            endcase
        endfunction

        // Compare one field byte against value and name at the current position
        function void match_char(logic [7:0] b);
            int unsigned p;
            p = byte_pos;
            if (p >= MATCH_BYTES || p >= regs.value_length ||
                regs.value_bytes[(p & 7) * 8 +: 8] != b)
                value_eq = 1'b0;
            if (p >= MATCH_BYTES || p >= regs.header_name_length ||
                regs.header_name_bytes[(p & 7) * 8 +: 8] != b)
                name_eq = 1'b0;
            if (p < MATCH_BYTES + 1)
                byte_pos = p + 1;
        endfunction

        function void close_field();
            bit eq_v;
            bit eq_n;
            eq_v = value_eq && byte_pos == regs.value_length;
            eq_n = name_eq && byte_pos == regs.header_name_length;
            if (!header_done) begin
                // Header: remember the first column whose name matches
                if (!name_seen && !field_sat && eq_n) begin
                    target_col = field_idx;
                    name_seen  = 1'b1;
                end
            end else if (regs.column_mode == MODE_NUMBER) begin
                if (regs.column_number != 0 && !field_sat &&
                    int'(field_idx) == int'(regs.column_number) - 1) begin
                    target_seen = 1'b1;
                    hit         = eq_v;
                end
            end else if (regs.column_mode == MODE_NAME) begin
                if (name_seen && !field_sat && field_idx == target_col) begin
                    target_seen = 1'b1;
                    hit         = eq_v;
                end
            end else if (eq_v) begin
                hit = 1'b1;
            end
            // Saturate the column index past the last indexed field
            if (!field_sat) begin
                if (int'(field_idx) >= FIELD_SLOTS - 1)
                    field_sat = 1'b1;
                else
                    field_idx = field_idx + 8'd1;
            end
            byte_pos = 0;
            value_eq = 1'b1;
            name_eq  = 1'b1;
        endfunction

        function void close_record();
            verdict_t v;
            if (byte_pos != 0)
                close_field();
            if (!header_done) begin
                v.keep_record   = 1'b1;
                v.is_header     = 1'b1;
                v.column_absent = regs.column_mode == MODE_NAME && !name_seen;
            end else begin
                v.keep_record   = hit ^ regs.drop_mode;
                v.is_header     = 1'b0;
                v.column_absent = (regs.column_mode == MODE_NUMBER ||
                                   regs.column_mode == MODE_NAME) && !target_seen;
            end
            expected_verdicts.insert(expected_verdicts.size(), v);
            header_done = 1'b1;
            field_idx   = '0;
            field_sat   = 1'b0;
            byte_pos    = 0;
            value_eq    = 1'b1;
            name_eq     = 1'b1;
            hit         = 1'b0;
            target_seen = 1'b0;
        endfunction

        // Note an accepted byte transaction and queue any verdict it causes
        function void accept_byte(byte_t t);
            if (t.data_byte == NEWLINE_BYTE) begin
                close_record();
            end else begin
                if (t.data_byte == regs.separator)
                    close_field();
                else
                    match_char(t.data_byte);
                if (t.stream_end)
                    close_record();
            end
            // Start a fresh stream: the next record is a header again
            if (t.stream_end) begin
                header_done = 1'b0;
                name_seen   = 1'b0;
                target_col  = '0;
            end
        endfunction

        function void note_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t ns: %s", $time, msg);
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
                note_error($sformatf("verdict %0d not expected: keep %0b header %0b absent %0b",
                                     verdicts_seen, got.keep_record, got.is_header,
                                     got.column_absent));
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.keep_record !== want.keep_record || got.is_header !== want.is_header ||
                got.column_absent !== want.column_absent)
                note_error($sformatf({"verdict %0d: keep exp %0b got %0b, header exp %0b ",
                                      "got %0b, absent exp %0b got %0b"},
                                     verdicts_seen, want.keep_record, got.keep_record,
                                     want.is_header, got.is_header,
                                     want.column_absent, got.column_absent));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and device under test
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   byte_valid;
    logic                   byte_ready;
    byte_t                  byte_data;
    logic                   verdict_valid;
    logic                   verdict_ready = 1'b0;
    verdict_t               verdict_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    csv_verdict_board verdicts;
    byte_t            text_q[$];
    int unsigned      send_idle_pct = 7;
    int unsigned      recv_idle_pct = 74;
    int unsigned      quiet_cycles  = 0;

    csv_record_match_filter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .byte_data     (byte_data),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_data  (verdict_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Receiver stalls, verdict checking and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        verdict_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && verdict_valid && verdict_ready)
            verdicts.check_verdict(verdict_data);
        if (!rst_n || (byte_valid && byte_ready) || (verdict_valid && verdict_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_csv_record_match_filter failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------------
    function automatic void put_byte(logic [7:0] b, logic last = 1'b0);
        byte_t t;
        t.data_byte  = b;
        t.stream_end = last;
        text_q.insert(text_q.size(), t);
    endfunction

    function automatic void put_text(string s, bit last);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], last && i == s.len() - 1);
    endfunction

    function automatic int cap_len(logic [3:0] n);
        return (int'(n) > MATCH_BYTES) ? MATCH_BYTES : int'(n);
    endfunction

    function automatic void put_word(logic [63:0] w, int n);
        for (int i = 0; i < n; i++)
            put_byte(w[i * 8 +: 8]);
    endfunction

    // Printable byte that never splits a field
    function automatic logic [7:0] plain_char(logic [7:0] sep);
        logic [7:0] b;
        do
            b = 8'($urandom_range(32, 126));
        while (b == sep);
        return b;
    endfunction

    function automatic logic [63:0] text_word(logic [7:0] sep);
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[i * 8 +: 8] = plain_char(sep);
        return w;
    endfunction

    // Mostly exact value or name, plus near misses, empty and long fields
    function automatic void put_field(cfg_t c);
        int unsigned k;
        k = $urandom_range(99);
        if (k < 35)
            put_word(c.value_bytes, cap_len(c.value_length));
        else if (k < 50)
            put_word(c.header_name_bytes, cap_len(c.header_name_length));
        else if (k < 60)
            ;
        else if (k < 70)
            repeat ($urandom_range(9, 11)) put_byte(plain_char(c.separator));
        else if (k < 80) begin
            put_word(c.value_bytes, cap_len(c.value_length));
            put_byte(plain_char(c.separator));
        end else if (k < 85)
            put_word(c.value_bytes, $urandom_range(0, cap_len(c.value_length)));
        else
            repeat ($urandom_range(1, 3)) put_byte(plain_char(c.separator));
    endfunction

    function automatic void put_record(cfg_t c, int nfields, int name_at, bit last, bit tiny);
        int start;
        start = text_q.size();
        for (int i = 0; i < nfields; i++) begin
            if (i > 0)
                put_byte(c.separator);
            if (i == name_at)
                put_word(c.header_name_bytes, cap_len(c.header_name_length));
            else if (!tiny)
                put_field(c);
            else if ($urandom_range(1))
                put_word(c.value_bytes, cap_len(c.value_length));
            else if ($urandom_range(1))
                put_byte(plain_char(c.separator));
        end
        if ($urandom_range(9) == 0)
            put_byte(c.separator);
        // End the stream on the last content byte or on the newline
        if (last && text_q.size() > start && $urandom_range(1))
            text_q[text_q.size() - 1].stream_end = 1'b1;
        else
            put_byte(NEWLINE_BYTE, last);
    endfunction

    // Streams of a header and data records; every phase closes its stream
    function automatic void build_phase(cfg_t c, bit wide);
        int nrec;
        int nf;
        bit wide_left;
        wide_left = wide;
        while (text_q.size() < PHASE_BYTES) begin
            nf = $urandom_range(1, 5);
            put_record(c, nf, $urandom_range(0, nf), 1'b0, 1'b0);
            nrec = $urandom_range(1, 8);
            for (int r = 0; r < nrec; r++) begin
                if (wide_left) begin
                    put_record(c, $urandom_range(FIELD_SLOTS + 1, FIELD_SLOTS + 14), -1,
                               r == nrec - 1, 1'b1);
                    wide_left = 1'b0;
                end else if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 6))
                        put_byte(8'($urandom_range(255)), $urandom_range(99) < 4);
                    put_byte(NEWLINE_BYTE, r == nrec - 1);
                end else begin
                    put_record(c, $urandom_range(0, 6), -1, r == nrec - 1, 1'b0);
                end
            end
        end
    endfunction

    function automatic cfg_t phase_settings(int p);
        cfg_t c;
        c = '0;
        case (p)
            0: begin c.separator = ",";  c.drop_mode = 1'b0; c.column_mode = MODE_NAME;
                     c.column_number = 8'd1;   c.value_length = 4'd3;  c.header_name_length = 4'd2; end
            1: begin c.separator = 8'hFF; c.drop_mode = 1'b1; c.column_mode = MODE_NUMBER;
                     c.column_number = 8'd2;   c.value_length = 4'd1;  c.header_name_length = 4'd0; end
            2: begin c.separator = NEWLINE_BYTE; c.drop_mode = 1'b0; c.column_mode = MODE_ANY;
                     c.column_number = 8'd3;   c.value_length = 4'd2;  c.header_name_length = 4'd1; end
            3: begin c.separator = ";";  c.drop_mode = 1'b1; c.column_mode = MODE_NUMBER;
                     c.column_number = 8'd0;   c.value_length = 4'd2;  c.header_name_length = 4'd2; end
            4: begin c.separator = 8'h00; c.drop_mode = 1'b0; c.column_mode = MODE_NUMBER;
                     c.column_number = 8'd255; c.value_length = 4'd0;  c.header_name_length = 4'd3; end
            5: begin c.separator = 8'h09; c.drop_mode = 1'b0; c.column_mode = MODE_SPARE;
                     c.column_number = 8'd4;   c.value_length = 4'd8;  c.header_name_length = 4'd8; end
            6: begin c.separator = ",";  c.drop_mode = 1'b1; c.column_mode = MODE_NAME;
                     c.column_number = 8'd1;   c.value_length = 4'd4;  c.header_name_length = 4'd8; end
            7: begin c.separator = "|";  c.drop_mode = 1'b0; c.column_mode = MODE_NAME;
                     c.column_number = 8'd7;   c.value_length = 4'd15; c.header_name_length = 4'd9; end
            default: begin c.separator = ","; c.drop_mode = 1'b1; c.column_mode = MODE_ANY;
                     c.column_number = 8'd1;   c.value_length = 4'd2;  c.header_name_length = 4'd0; end
        endcase
        c.value_bytes       = (p == 5) ? '1 : text_word(c.separator);
        c.header_name_bytes = text_word(c.separator);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        verdicts.write_reg(idx, val);
        // Hold valid when another write follows
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(cfg_t c);
        logic [63:0] junk;
        // Unused upper data bits carry noise half of the time
        junk = $urandom_range(1) ? {$urandom, $urandom} : 64'd0;
        write_reg(REG_SEPARATOR,          {junk[63:8], c.separator},          1'b1);
        write_reg(REG_DROP_MODE,          {junk[63:1], c.drop_mode},          1'b1);
        write_reg(REG_COLUMN_MODE,        {junk[63:2], c.column_mode},        1'b1);
        write_reg(REG_COLUMN_NUMBER,      {junk[63:8], c.column_number},      1'b1);
        write_reg(REG_VALUE_BYTES,        c.value_bytes,                      1'b1);
        write_reg(REG_VALUE_LENGTH,       {junk[63:4], c.value_length},       1'b1);
        write_reg(REG_HEADER_NAME_BYTES,  c.header_name_bytes,                1'b1);
        write_reg(REG_HEADER_NAME_LENGTH, {junk[63:4], c.header_name_length}, 1'b0);
    endtask

    // Drain the text queue, one byte transaction at a time
    task automatic send_stream();
        byte_t b;
        while (text_q.size() != 0) begin
            b = text_q.pop_front();
            if ($urandom_range(99) < send_idle_pct) begin
                byte_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < send_idle_pct);
            end
            byte_valid <= 1'b1;
            byte_data  <= b;
            @(posedge clk);
            while (!byte_ready) @(posedge clk);
            verdicts.accept_byte(b);
        end
        byte_valid <= 1'b0;
    endtask

    // Wait for every expected verdict, then let the pipeline go quiet
    task automatic settle();
        while (verdicts.expected_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        cfg_t settings;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_data  <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        verdicts = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text under reset settings
        put_text("h\n", 1'b0);         // header record
        put_text(",\n", 1'b0);         // empty field equals the empty value
        put_text("\n", 1'b0);          // empty line has no fields
        put_text("ab\n", 1'b0);        // field with no match
        put_byte(8'hFF, 1'b1);         // stream end closes an open record
        put_byte(8'h00, 1'b1);         // one-byte header of a new stream
        put_byte(NEWLINE_BYTE, 1'b1);  // newline that also ends the stream
        send_stream();

        // Three stall regimes, three settings each
        for (int r = 0; r < 3; r++) begin
            send_idle_pct = (r == 0) ? 7 : (r == 1) ? 74 : 0;
            recv_idle_pct = (r == 0) ? 74 : (r == 1) ? 7 : 0;
            for (int k = 0; k < 3; k++) begin
                settings = phase_settings(r * 3 + k);
                settle();
                load_settings(settings);
                build_phase(settings, (r * 3 + k == 4) || (r * 3 + k == 8));
                send_stream();
            end
        end
        settle();

        if (verdicts.mismatches == 0)
            $display("tb_csv_record_match_filter passed");
        else
            $display("tb_csv_record_match_filter failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/crmf_pkg.sv
rtl/crmf_parser.sv
rtl/csv_record_match_filter.sv
tb/sv/tb_csv_record_match_filter.sv
